FILE: hw/rtl/icp_pkg.sv
// Shared types and constants for the inversion count and parity block.
package icp_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 19;
  localparam int unsigned CNT_W     = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned ITEM_W    = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } inv_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] inversion_count;
    logic               odd_parity;
    logic               overflow;
  } inv_out_t;

  // Token that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic                      valid;
    logic                      active;
    logic                      placed;
    logic                      last;
    logic signed [VALUE_W-1:0] key;
    logic [CNT_W-1:0]          cnt;
  } icp_tok_t;

endpackage

FILE: hw/rtl/icp_cell.sv
// One compare cell: holds a stored value and counts it against passing tokens.
module icp_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  icp_pkg::icp_tok_t tok_i,
  output icp_pkg::icp_tok_t tok_o
);

  logic                               occ_q, occ_d;
  logic signed [icp_pkg::VALUE_W-1:0] value_q, value_d;
  icp_pkg::icp_tok_t                  tok_q, tok_d;

  always_comb begin
    tok_d   = tok_i;
    occ_d   = occ_q;
    value_d = value_q;
    if (tok_i.valid && tok_i.active) begin
      if (occ_q) begin
        if ($signed(value_q) > $signed(tok_i.key)) begin
          tok_d.cnt = tok_i.cnt + icp_pkg::CNT_W'(1);
        end
      end else if (!tok_i.placed) begin
        // first free cell keeps the key
        occ_d        = 1'b1;
        value_d      = tok_i.key;
        tok_d.placed = 1'b1;
      end
    end
    if (clear_i) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= '0;
    end else begin
      occ_q <= occ_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign tok_o = tok_q;

endmodule

FILE: hw/rtl/inversion_count_parity.sv
// Inversion count with parity: a row of compare cells, one transfer per cycle while not busy.
// Throughput: one item per cycle inside a sequence; each item walks the row of
//   MAX_ITEMS cells, one cell per cycle, collecting its count of greater values.
// The result strobe follows the last-item transfer once its token has left the
//   cell row and passed the result register; busy holds from that transfer
//   until the strobe. The result cannot be stalled.
// Reset: asynchronous, active low; clears counters, flags, cell occupancy, tokens.
module inversion_count_parity (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  icp_pkg::inv_in_t  in_i,
  output logic              result_valid_o,
  output icp_pkg::inv_out_t result_o
);

  icp_pkg::icp_tok_t tok [icp_pkg::MAX_ITEMS+1];

  logic                        accept;
  logic                        room;
  logic [icp_pkg::ITEM_W-1:0]  item_cnt_q, item_cnt_d;
  logic                        ovf_q, ovf_d;
  logic                        busy_q, busy_d;
  logic [icp_pkg::COUNT_W-1:0] total_q, total_d;
  logic                        par_q, par_d;
  logic [icp_pkg::COUNT_W:0]   sum;
  logic                        done;
  logic                        res_valid_q;
  icp_pkg::inv_out_t           res_q, res_d;
  icp_pkg::icp_tok_t           tail;

  // A transfer happens while no finished sequence is still draining.
  assign accept = start && !busy_q;
  assign room   = (item_cnt_q != icp_pkg::ITEM_W'(icp_pkg::MAX_ITEMS));

  // Inject the token at the head of the row; an item past capacity walks
  // inactive so that a last flag on it still ends the sequence.
  always_comb begin
    tok[0].valid  = accept;
    tok[0].active = room;
    tok[0].placed = 1'b0;
    tok[0].last   = in_i.last_item;
    tok[0].key    = in_i.value;
    tok[0].cnt    = '0;
  end

  for (genvar g = 0; g < icp_pkg::MAX_ITEMS; g++) begin : g_cell
    icp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (done),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  assign tail = tok[icp_pkg::MAX_ITEMS];
  assign done = tail.valid && tail.last;

  // Accumulate each token's count as it leaves the row; saturate the total,
  // keep parity of the exact count.
  always_comb begin
    sum        = {1'b0, total_q} + (icp_pkg::COUNT_W+1)'(tail.cnt);
    total_d    = total_q;
    par_d      = par_q;
    item_cnt_d = item_cnt_q;
    ovf_d      = ovf_q;
    busy_d     = busy_q;
    res_d      = res_q;

    if (accept) begin
      if (room) begin
        item_cnt_d = item_cnt_q + icp_pkg::ITEM_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (in_i.last_item) begin
        busy_d = 1'b1;
      end
    end

    if (tail.valid && tail.active) begin
      total_d = sum[icp_pkg::COUNT_W] ? '1 : sum[icp_pkg::COUNT_W-1:0];
      par_d   = par_q ^ tail.cnt[0];
    end

    if (done) begin
      res_d.inversion_count = total_d;
      res_d.odd_parity      = par_d;
      res_d.overflow        = ovf_q;
      // drop all sequence state for the next run
      total_d    = '0;
      par_d      = 1'b0;
      item_cnt_d = '0;
      ovf_d      = 1'b0;
      busy_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      busy_q      <= 1'b0;
      total_q     <= '0;
      par_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      item_cnt_q  <= item_cnt_d;
      ovf_q       <= ovf_d;
      busy_q      <= busy_d;
      total_q     <= total_d;
      par_q       <= par_d;
      res_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A last-item transfer holds off further input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.last_item |=> busy)
    else $error("busy not raised after last-item transfer");

  // The tail seeing the last token gives a result strobe next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> result_valid_o)
    else $error("result strobe missing after sequence drain");

  // One strobe per sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe repeated");

  // Unsaturated count agrees with the parity bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.inversion_count != '1) |->
      (result_o.odd_parity == result_o.inversion_count[0]))
    else $error("parity disagrees with inversion count");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the inversion count and parity block.
`timescale 1ns / 1ps

module tb;

  typedef enum int unsigned {VAL_FULL, VAL_NARROW, VAL_EDGE, VAL_MIX} val_mode_e;

  // One queued input transfer; hold_for_drain keeps it back until every
  // expected result has been checked.
  typedef struct {
    icp_pkg::inv_in_t item;
    bit               hold_for_drain;
  } feed_t;

  localparam int unsigned COUNT_CAP   = (1 << icp_pkg::COUNT_W) - 1;
  localparam int unsigned RANDOM_SEQS = 80;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start  = 1'b0;
  logic              busy;
  icp_pkg::inv_in_t  in_i   = '0;
  logic              result_valid_o;
  icp_pkg::inv_out_t result_o;

  feed_t             feed_queue[$];
  icp_pkg::inv_out_t inv_expected[$];
  feed_t             feed;
  icp_pkg::inv_out_t want;

  // Inversion state of the sequence in flight, as the block should hold it.
  logic [icp_pkg::VALUE_W-1:0] seq_vals[icp_pkg::MAX_ITEMS];
  int unsigned                 seq_len;
  int unsigned                 seq_total;
  bit                          seq_odd;
  bit                          seq_overflow;

  bit          taken;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned fail_count;

  inversion_count_parity dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fold one accepted value into the running inversion count; on the last item,
  // queue the expected result and clear for the next sequence.
  task automatic absorb_value(input icp_pkg::inv_in_t item);
    int unsigned       greater;
    icp_pkg::inv_out_t res;
    greater = 0;
    if (seq_len < icp_pkg::MAX_ITEMS) begin
      for (int i = 0; i < seq_len; i++) begin
        if ($signed(seq_vals[i]) > $signed(item.value)) greater++;
      end
      seq_odd ^= greater[0];
      // Saturate at the width of the count; parity keeps tracking the exact total.
      if (greater > COUNT_CAP - seq_total) seq_total = COUNT_CAP;
      else seq_total += greater;
      seq_vals[seq_len] = item.value;
      seq_len++;
    end else begin
      seq_overflow = 1'b1;
    end
    if (item.last_item) begin
      res.inversion_count = seq_total[icp_pkg::COUNT_W-1:0];
      res.odd_parity      = seq_odd;
      res.overflow        = seq_overflow;
      inv_expected.push_back(res);
      seq_len      = 0;
      seq_total    = 0;
      seq_odd      = 1'b0;
      seq_overflow = 1'b0;
    end
  endtask

  function automatic logic [icp_pkg::VALUE_W-1:0] pick_value(input val_mode_e mode);
    val_mode_e m;
    m = (mode == VAL_MIX) ? val_mode_e'($urandom_range(0, 2)) : mode;
    case (m)
      VAL_NARROW: return icp_pkg::VALUE_W'($urandom_range(0, 8)) - icp_pkg::VALUE_W'(4);
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 9) return $urandom_range(1, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic push_item(input logic [icp_pkg::VALUE_W-1:0] value, input bit last,
                           input bit hold = 1'b0);
    feed_t f;
    f.item.value     = value;
    f.item.last_item = last;
    f.hold_for_drain = hold;
    feed_queue.push_back(f);
  endtask

  task automatic queue_sequence(input int unsigned len, input val_mode_e mode,
                                input bit hold);
    for (int unsigned i = 0; i < len; i++) begin
      push_item(pick_value(mode), i == len - 1, hold && i == 0);
    end
  endtask

  // Driver: present the next transfer at the falling edge, in bursts with gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold the current transfer until the block takes it
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (feed_queue.size() == 0 ||
                 (feed_queue[0].hold_for_drain && inv_expected.size() != 0)) begin
      start <= 1'b0;
    end else begin
      feed  = feed_queue.pop_front();
      in_i  <= feed.item;
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= pick_gap();
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Monitor: at the rising edge, check any result strobe, then record a transfer.
  always @(posedge clk_i) begin
    taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (inv_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result: count=%0d odd=%0b overflow=%0b", $time,
                     result_o.inversion_count, result_o.odd_parity, result_o.overflow);
        end else begin
          want = inv_expected.pop_front();
          if (result_o.inversion_count !== want.inversion_count ||
              result_o.odd_parity !== want.odd_parity ||
              result_o.overflow !== want.overflow) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: expected count=%0d odd=%0b overflow=%0b",
                       $time, want.inversion_count, want.odd_parity, want.overflow);
              $display("%0t: mismatch: got count=%0d odd=%0b overflow=%0b",
                       $time, result_o.inversion_count, result_o.odd_parity,
                       result_o.overflow);
            end
          end
        end
      end
      if (start && !busy) begin
        absorb_value(in_i);
      end
    end
  end

  initial begin
    // Directed: lone items at both extremes.
    push_item(32'h8000_0000, 1'b1);
    push_item(32'h7FFF_FFFF, 1'b1);
    // Extremes mixed with repeats; equal pairs must not count.
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h0000_0000, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h8000_0000, 1'b1);
    // Strictly descending run: every pair is an inversion.
    push_item(32'd3, 1'b0);
    push_item(32'd2, 1'b0);
    push_item(32'd1, 1'b0);
    push_item(32'd0, 1'b1);
    // All equal: no inversions.
    push_item(32'd5, 1'b0);
    push_item(32'd5, 1'b0);
    push_item(32'd5, 1'b1);
    // One swap gives odd parity.
    push_item(32'd2, 1'b0);
    push_item(32'd1, 1'b1);

    // Random sequences, mostly short; one runs past capacity, ending on a dropped item.
    for (int unsigned s = 0; s < RANDOM_SEQS; s++) begin
      if (s == RANDOM_SEQS / 2)
        queue_sequence(icp_pkg::MAX_ITEMS + 2, VAL_MIX, 1'b0);
      queue_sequence($urandom_range(1, 22), val_mode_e'($urandom_range(0, 3)),
                     s == 0 || $urandom_range(0, 7) == 0);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (feed_queue.size() != 0 || start) @(posedge clk_i);
    while (inv_expected.size() != 0) @(posedge clk_i);
    // Let a spurious late strobe show up before closing.
    repeat (icp_pkg::MAX_ITEMS + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("inversion_count_parity verification clean");
    end else begin
      $display("inversion_count_parity verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("inversion_count_parity verification failed");
    $finish;
  end

endmodule
